// ===== design/graph_reachability_engine_core_macros.svh =====
// Assertion macros shared by the graph reachability engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef GRAPH_REACHABILITY_ENGINE_CORE_MACROS_SVH
`define GRAPH_REACHABILITY_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GRRE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("graph reachability engine: check failed");

// Next-cycle implication, disabled while reset is high.
`define GRRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("graph reachability engine: check failed");

`endif

// ===== design/grre_pkg.sv =====
// Package for the graph reachability engine: field widths, mode and
// register codes, and the pick result type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package grre_pkg;

   localparam int STATE_W = 6;
   localparam int COUNT_W = 7;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [0:0] CSR_STATE_COUNT   = 1'b0;
   localparam logic [0:0] CSR_REVERSE_EDGES = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [COUNT_W-1:0] RESET_STATE_COUNT = 7'd64;

   // Result of the lowest-pending-state search.
   typedef struct packed {
      logic               found;
      logic [STATE_W-1:0] index;
   } pick_type;

endpackage

`default_nettype wire

// ===== design/grre_lowbit.sv =====
// Lowest-set-bit picker used to choose the next state to expand.
// Depends on grre_pkg for the pick result type.
`timescale 1ns / 1ps
`default_nettype none

module grre_lowbit
   import grre_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] vec,
   output pick_type         pick
);

   logic [WIDTH-1:0]   onehot;
   logic [STATE_W-1:0] index;

   // Two's complement trick isolates the lowest set bit.
   assign onehot = vec & (~vec + WIDTH'(1));

   always_comb begin
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (onehot[i]) begin
            index = index | STATE_W'(i);
         end
      end
   end

   assign pick.found = |vec;
   assign pick.index = index;

endmodule

`default_nettype wire

// ===== design/graph_reachability_engine_core.sv =====
// Graph reachability engine core: adjacency matrix memory and search sequencer.
// An add passes ST_ADD_WR and ST_FINISH before its result is registered; clear and rejected
// items go straight to ST_FINISH. A query reads one row per cycle from the single port, and
// a chain is walked one row read at a time. The next item is accepted as the result turns valid.
// Synchronous active-high reset empties the graph through per-row valid bits at once.
// Depends on grre_pkg, grre_lowbit and graph_reachability_engine_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "graph_reachability_engine_core_macros.svh"

module graph_reachability_engine_core
   import grre_pkg::*;
#(
   parameter int MAX_STATES = 64
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [STATE_W-1:0] req_from_state,
   input  logic [STATE_W-1:0] req_to_state,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_reachable,
   output logic               rsp_status,

   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [COUNT_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_STATES);
   localparam logic [MAX_STATES-1:0] ROW_ONE   = MAX_STATES'(1);
   localparam logic [COUNT_W-1:0]    MAX_COUNT = COUNT_W'(MAX_STATES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Sequencer state and registered outputs.
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_reach_ff, rsp_reach_in;
   logic               rsp_status_ff, rsp_status_in;

   // Result of the item in progress, waiting for the output register.
   logic               res_reach_ff, res_reach_in;
   logic               res_status_ff, res_status_in;

   // Configuration registers.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               reverse_ff, reverse_in;

   // Latched operands: the row and column for an edge, the target for a query.
   logic [ADDR_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0]  tgt_ff, tgt_in;

   // Search sets and the flag for a row read that is still on its way.
   logic [MAX_STATES-1:0] visited_ff, visited_in;
   logic [MAX_STATES-1:0] expanded_ff, expanded_in;
   logic                  inflight_ff, inflight_in;

   // A row that is not valid reads as all zero; clear only drops these bits.
   logic [MAX_STATES-1:0] row_valid_ff, row_valid_in;

   // Adjacency memory: one write port, one registered read port.
   logic [MAX_STATES-1:0] adj_mem_ff [MAX_STATES];
   logic [MAX_STATES-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [MAX_STATES-1:0] wr_data;

   logic [COUNT_W-1:0]    eff_count;
   logic [MAX_STATES-1:0] valid_mask;
   logic [MAX_STATES-1:0] rd_row;
   logic                  req_bad;
   logic [ADDR_W-1:0]     from_addr;
   logic [ADDR_W-1:0]     to_addr;
   pick_type              pick;
   logic [ADDR_W-1:0]     pick_addr;

   // A programmed count above the matrix size acts as the matrix size.
   assign eff_count = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;

   always_comb begin
      for (int i = 0; i < MAX_STATES; i++) begin
         valid_mask[i] = COUNT_W'(i) < eff_count;
      end
   end

   assign req_bad = ({1'b0, req_from_state} >= eff_count) ||
                    ({1'b0, req_to_state} >= eff_count);
   assign from_addr = req_from_state[ADDR_W-1:0];
   assign to_addr   = req_to_state[ADDR_W-1:0];

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

   // The picker chooses the lowest visited state not yet expanded.
   grre_lowbit #(
      .WIDTH (MAX_STATES)
   ) u_lowbit (
      .vec  (visited_ff & ~expanded_ff),
      .pick (pick)
   );

   assign pick_addr = pick.index[ADDR_W-1:0];

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_reach_in  = rsp_reach_ff;
      rsp_status_in = rsp_status_ff;
      res_reach_in  = res_reach_ff;
      res_status_in = res_status_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      tgt_in        = tgt_ff;
      visited_in    = visited_ff;
      expanded_in   = expanded_ff;
      inflight_in   = 1'b0;
      row_valid_in  = row_valid_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_data       = rd_row | (ROW_ONE << col_ff);
      count_in      = count_ff;
      reverse_in    = reverse_ff;

      // Configuration must be written only while the engine is idle; the block does not enforce this.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STATE_COUNT:   count_in   = csr_write_data;
            CSR_REVERSE_EDGES: reverse_in = csr_write_data[0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_reach_in  = 1'b0;
               res_status_in = STATUS_OK;
               tgt_in        = to_addr;
               row_in        = reverse_ff ? to_addr : from_addr;
               col_in        = reverse_ff ? from_addr : to_addr;
               state_in      = ST_FINISH;
               unique case (req_mode)
                  MODE_ADD: begin
                     if (req_bad) begin
                        res_status_in = STATUS_BAD;
                     end else begin
                        // Read the old row now, merge the new bit next cycle.
                        rd_en    = 1'b1;
                        rd_addr  = reverse_ff ? to_addr : from_addr;
                        state_in = ST_ADD_WR;
                     end
                  end
                  MODE_QUERY: begin
                     if (req_bad) begin
                        res_status_in = STATUS_BAD;
                     end else begin
                        visited_in  = ROW_ONE << from_addr;
                        expanded_in = '0;
                        state_in    = ST_SEARCH;
                     end
                  end
                  MODE_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                     // The unused mode leaves everything as it is.
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            wr_en                = 1'b1;
            row_valid_in[row_ff] = 1'b1;
            state_in             = ST_FINISH;
         end
         ST_SEARCH: begin
            // Fold in the row that was read last cycle, limited to states in use.
            if (inflight_ff) begin
               visited_in = visited_ff | (rd_row & valid_mask);
            end
            if (pick.found) begin
               rd_en       = 1'b1;
               rd_addr     = pick_addr;
               expanded_in = expanded_ff | (ROW_ONE << pick_addr);
               inflight_in = 1'b1;
            end else if (!inflight_ff) begin
               res_reach_in = visited_ff[tgt_ff];
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_reach_in  = res_reach_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         inflight_ff  <= 1'b0;
         row_valid_ff <= '0;
         count_ff     <= RESET_STATE_COUNT;
         reverse_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         inflight_ff  <= inflight_in;
         row_valid_ff <= row_valid_in;
         count_ff     <= count_in;
         reverse_ff   <= reverse_in;
      end
      rsp_reach_ff  <= rsp_reach_in;
      rsp_status_ff <= rsp_status_in;
      res_reach_ff  <= res_reach_in;
      res_status_ff <= res_status_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      tgt_ff        <= tgt_in;
      visited_ff    <= visited_in;
      expanded_ff   <= expanded_in;
   end

   // Memory ports; the read valid bit travels with the read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem_ff[row_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= adj_mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // Every expanded state must have been visited first.
   `GRRE_ASSERT_IMPL(a_expanded_in_visited, clock, reset,
      state_ff == ST_SEARCH, (expanded_ff & ~visited_ff) == '0)

   // The expanded set only grows during a search.
   `GRRE_ASSERT_IMPL(a_expanded_grows, clock, reset,
      (state_ff == ST_SEARCH) && ($past(state_ff) == ST_SEARCH),
      ($past(expanded_ff) & ~expanded_ff) == '0)

   // A row read is outstanding only while searching.
   `GRRE_ASSERT_IMPL(a_inflight_in_search, clock, reset,
      inflight_ff, state_ff == ST_SEARCH)

   // A rejected item never reports reachability.
   `GRRE_ASSERT_IMPL(a_bad_not_reachable, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_BAD), !rsp_reach_ff)

endmodule

`default_nettype wire

// ===== tb/sv/grre_reach_checker.sv =====
// Result checker for the graph reachability engine: mirrors the adjacency
// matrix and the configuration registers, predicts each reply and compares it
// field by field. Depends on grre_pkg.
`timescale 1ns / 1ps

module grre_reach_checker
   import grre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [STATE_W-1:0] req_from_state,
   input  logic [STATE_W-1:0] req_to_state,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_reachable,
   input  logic               rsp_status,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [COUNT_W-1:0] csr_write_data,
   output int                 mismatch_count,
   output int                 verdicts_waiting
);

   localparam int NUM_STATES = 1 << STATE_W;

   typedef struct packed {
      logic reachable;
      logic status;
   } verdict_type;

   logic [NUM_STATES-1:0] edge_rows [NUM_STATES];
   logic [COUNT_W-1:0]    state_limit;
   logic                  reverse_mode;
   verdict_type           pending_verdicts [$];

   initial begin
      mismatch_count   = 0;
      verdicts_waiting = 0;
   end

   function automatic int usable_states();
      return (int'(state_limit) > NUM_STATES) ? NUM_STATES : int'(state_limit);
   endfunction

   // Closure of the edge relation from one origin, following only edges that
   // land below the current state count.
   function automatic logic [NUM_STATES-1:0] reached_states(int origin, int n);
      logic [NUM_STATES-1:0] keep;
      logic [NUM_STATES-1:0] seen;
      logic [NUM_STATES-1:0] prior;
      keep = '0;
      for (int s = 0; s < n; s++) keep[s] = 1'b1;
      seen = '0;
      seen[origin] = 1'b1;
      do begin
         prior = seen;
         for (int s = 0; s < NUM_STATES; s++) begin
            if (seen[s]) seen |= edge_rows[s] & keep;
         end
      end while (seen != prior);
      return seen;
   endfunction

   function automatic verdict_type reach_verdict(logic [1:0] mode,
                                                 logic [STATE_W-1:0] src,
                                                 logic [STATE_W-1:0] dst);
      verdict_type           v;
      int                    n;
      logic [NUM_STATES-1:0] seen;
      v = '0;
      v.status = STATUS_OK;
      n = usable_states();
      case (mode)
         MODE_ADD, MODE_QUERY: begin
            if (int'(src) >= n || int'(dst) >= n) begin
               v.status = STATUS_BAD;
            end else if (mode == MODE_ADD) begin
               if (reverse_mode) edge_rows[dst][src] = 1'b1;
               else edge_rows[src][dst] = 1'b1;
            end else begin
               seen = reached_states(int'(src), n);
               v.reachable = seen[dst];
            end
         end
         MODE_CLEAR: begin
            foreach (edge_rows[s]) edge_rows[s] = '0;
         end
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type oldest;
      if (reset) begin
         foreach (edge_rows[s]) edge_rows[s] = '0;
         state_limit  = RESET_STATE_COUNT;
         reverse_mode = 1'b0;
         pending_verdicts.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STATE_COUNT:   state_limit  = csr_write_data;
               CSR_REVERSE_EDGES: reverse_mode = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_verdicts.push_back(reach_verdict(req_mode, req_from_state, req_to_state));
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid is unknown");
            mismatch_count++;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result: reachable %0b, status %0b",
                      rsp_reachable, rsp_status);
               mismatch_count++;
            end else begin
               oldest = pending_verdicts.pop_front();
               if (rsp_reachable !== oldest.reachable) begin
                  $error("reachable: expected %0b, actual %0b", oldest.reachable, rsp_reachable);
                  mismatch_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0b, actual %0b", oldest.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
      verdicts_waiting = pending_verdicts.size();
   end

endmodule

// ===== tb/sv/tb_graph_reachability_engine_core.sv =====
// Top of the graph reachability engine testbench: clock, reset, stimulus and
// the final verdict. Depends on grre_pkg, graph_reachability_engine_core and
// grre_reach_checker.
`timescale 1ns / 1ps

module tb_graph_reachability_engine_core;
   import grre_pkg::*;

   localparam int NUM_STATES = 1 << STATE_W;

   // The fourth mode code has no meaning; the block must answer it with 0, 0.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Items per configuration segment; three idling phases of six segments
   // each give roughly 1350 items in all.
   localparam int SEGMENT_ITEMS = 75;
   localparam int SEGMENTS      = 6;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [STATE_W-1:0] req_from_state;
   logic [STATE_W-1:0] req_to_state;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_reachable;
   logic               rsp_status;
   logic               csr_write_enable;
   logic [0:0]         csr_index;
   logic [COUNT_W-1:0] csr_write_data;

   int mismatch_count;
   int verdicts_waiting;

   // Stimulus bookkeeping. cur_count mirrors the state count register so
   // that most generated indices land inside the live range.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cur_count      = 64;
   int sent_items     = 0;

   graph_reachability_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_from_state   (req_from_state),
      .req_to_state     (req_to_state),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reachable    (rsp_reachable),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   grre_reach_checker reach_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_from_state   (req_from_state),
      .req_to_state     (req_to_state),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reachable    (rsp_reachable),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .verdicts_waiting (verdicts_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver decides once per cycle, at the falling edge, whether it
   // will take a result at the next rising edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs; it leaves room for a run in which every
   // query walks the whole graph.
   initial begin
      #(10_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int usable_count();
      return (cur_count > NUM_STATES) ? NUM_STATES : cur_count;
   endfunction

   // Presents one item at a falling edge, after a random number of idle
   // cycles, and returns at the rising edge where it is accepted.
   task automatic send_item(input logic [1:0] mode, input logic [STATE_W-1:0] src,
                            input logic [STATE_W-1:0] dst);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_from_state <= src;
      req_to_state   <= dst;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   // Stops sending and waits until every outstanding result has arrived.
   // Every item produces exactly one result, so the block is idle then.
   task automatic drain_items();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_waiting != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input int count, input logic rev);
      write_reg(CSR_STATE_COUNT, count[COUNT_W-1:0]);
      write_reg(CSR_REVERSE_EDGES, {{(COUNT_W-1){1'b0}}, rev});
      cur_count = count;
   endtask

   // One random item: mostly adds and queries inside the live range, a few
   // out-of-range indices, rare clears and the occasional unused mode.
   task automatic random_item();
      int                 n;
      int                 pick;
      logic [1:0]         mode;
      logic [STATE_W-1:0] src;
      logic [STATE_W-1:0] dst;
      n = usable_count();
      pick = $urandom_range(0, 99);
      if (pick < 46) mode = MODE_ADD;
      else if (pick < 95) mode = MODE_QUERY;
      else if (pick < 97) mode = MODE_CLEAR;
      else mode = MODE_UNUSED;
      if (n > 0 && $urandom_range(0, 9) != 0) begin
         src = STATE_W'($urandom_range(0, n - 1));
         dst = STATE_W'($urandom_range(0, n - 1));
      end else begin
         src = STATE_W'($urandom_range(0, NUM_STATES - 1));
         dst = STATE_W'($urandom_range(0, NUM_STATES - 1));
      end
      send_item(mode, src, dst);
   endtask

   // Lays down a path of edges and asks about both of its ends. A rare long
   // path runs downward through every live state, which makes the search
   // pick one new state per row read and gives the slowest queries.
   task automatic chain_burst();
      int                 n;
      int                 len;
      logic               long_chain;
      logic [STATE_W-1:0] head;
      logic [STATE_W-1:0] node;
      logic [STATE_W-1:0] next_node;
      n = usable_count();
      if (n < 2) begin
         random_item();
         return;
      end
      long_chain = ($urandom_range(0, 24) == 0);
      len  = long_chain ? n : $urandom_range(2, (n < 12) ? n : 12);
      head = long_chain ? STATE_W'(n - 1) : STATE_W'($urandom_range(0, n - 1));
      node = head;
      for (int k = 1; k < len; k++) begin
         next_node = long_chain ? node - STATE_W'(1) : STATE_W'($urandom_range(0, n - 1));
         send_item(MODE_ADD, node, next_node);
         node = next_node;
      end
      send_item(MODE_QUERY, head, node);
      send_item(MODE_QUERY, node, head);
   endtask

   initial begin
      int target;
      int pick;
      int seg_count;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ADD;
      req_from_state   = '0;
      req_to_state     = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_STATE_COUNT;
      csr_write_data   = '0;

      // The directed part runs under the first idling mix.
      send_idle_pct  = 6;
      recv_stall_pct = 65;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset settings of 64 states, edges forward.
      // A state reaches itself even with an empty graph.
      send_item(MODE_QUERY, 0, 0);
      send_item(MODE_QUERY, 0, 63);
      send_item(MODE_ADD, 0, 63);
      send_item(MODE_ADD, 63, 5);
      send_item(MODE_QUERY, 0, 5);
      send_item(MODE_QUERY, 5, 0);
      send_item(MODE_ADD, 63, 63);
      send_item(MODE_UNUSED, 63, 63);
      // Clearing must wipe every row, so the two-hop path above disappears.
      send_item(MODE_CLEAR, 0, 0);
      send_item(MODE_QUERY, 0, 5);
      // This path runs through state 50, which the next setting cuts off.
      send_item(MODE_ADD, 10, 50);
      send_item(MODE_ADD, 50, 11);
      drain_items();

      // Lowered count with reversed edges: the stored edge into state 50
      // must no longer be followed, and index 50 itself is rejected.
      set_config(40, 1'b1);
      send_item(MODE_QUERY, 10, 11);
      send_item(MODE_QUERY, 10, 50);
      send_item(MODE_ADD, 3, 7);
      send_item(MODE_QUERY, 7, 3);
      send_item(MODE_QUERY, 3, 7);
      send_item(MODE_ADD, 45, 2);
      drain_items();

      // A count of zero rejects every index; a clear still goes through.
      set_config(0, 1'b0);
      send_item(MODE_QUERY, 0, 0);
      send_item(MODE_CLEAR, 0, 0);
      drain_items();

      // A count above the matrix size behaves like the full size.
      set_config(127, 1'b0);
      send_item(MODE_ADD, 63, 0);
      send_item(MODE_QUERY, 63, 0);
      drain_items();

      // A single live state: only state 0 is addressable.
      set_config(1, 1'b0);
      send_item(MODE_QUERY, 0, 0);
      send_item(MODE_ADD, 0, 1);
      drain_items();

      // Random part in three idling phases: mostly receiver stalls, then
      // mostly sender gaps, then full throughput. Each phase walks through
      // several settings, drained in between so writes hit an idle block.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 6;
               recv_stall_pct = 65;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 6;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0:       seg_count = 1;
               1:       seg_count = 2;
               2:       seg_count = 0;
               3:       seg_count = 127;
               4:       seg_count = $urandom_range(65, 126);
               5, 6:    seg_count = 64;
               default: seg_count = $urandom_range(3, 63);
            endcase
            set_config(seg_count, 1'($urandom_range(0, 1)));
            target = sent_items + SEGMENT_ITEMS;
            if ($urandom_range(0, 1) == 0) send_item(MODE_CLEAR, 0, 0);
            while (sent_items < target) begin
               if ($urandom_range(0, 4) == 0) chain_burst();
               else random_item();
               // Now and then the sender holds off until the block has
               // handed back every result.
               if ($urandom_range(0, 49) == 0) drain_items();
            end
            drain_items();
         end
      end

      // Watch for stray results for about the length of the slowest query.
      repeat (2 * NUM_STATES + 4) @(negedge clock);

      if (mismatch_count == 0 && verdicts_waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
